@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; expects clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is high
`define RAU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset
`define RAU_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/rau_pkg.sv @@
// Shared constants, opcodes and controller/datapath command types
// for the rational arithmetic unit. No dependencies.
package rau_pkg;

   localparam int WIDTH = 32;
   localparam int DW    = 2 * WIDTH;
   localparam int CNT_W = $clog2(DW);
   localparam int OPC_W = 3;
   localparam int FW    = 32;
   localparam int DEN_W = 31;

   typedef enum logic [OPC_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_RECIP = 3'd4,
      OP_NEG   = 3'd5,
      OP_NORM  = 3'd6,
      OP_CMP   = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      MSEL_P0 = 2'd0,
      MSEL_P1 = 2'd1,
      MSEL_P2 = 2'd2
   } msel_type;

   typedef struct packed {
      logic     load;
      logic     mul;
      msel_type mul_sel;
      logic     combine;
      logic     gcd_start;
      logic     gcd_step;
      logic     div_setup;
      logic     div_step;
      logic     finish;
   } rau_cmd_type;

   typedef struct packed {
      logic early;
      logic gcd_done;
      logic div_last;
   } rau_status_type;

   typedef struct packed {
      logic             neg;
      logic [WIDTH-1:0] mag;
   } smw_type;

   typedef struct packed {
      logic          neg;
      logic [DW-1:0] mag;
   } smd_type;

endpackage

@@ src/rau_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on rau_pkg.
interface rau_req_if;
   import rau_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic signed [FW-1:0]    a_num;
   logic signed [FW-1:0]    a_den;
   logic signed [FW-1:0]    b_num;
   logic signed [FW-1:0]    b_den;
   modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [FW-1:0] res_num;
   logic [DEN_W-1:0]     res_den;
   logic                 less;
   logic                 equal;
   logic                 greater;
   logic                 zero_den_error;
   logic                 overflow;
   modport source (output valid, res_num, res_den, less, equal, greater, zero_den_error,
                   overflow, input ready);
   modport sink   (input valid, res_num, res_den, less, equal, greater, zero_den_error,
                   overflow, output ready);
endinterface

@@ src/rau_ctrl.sv @@
// Controller state machine: sequences multiply, combine, gcd and divide.
// Depends on rau_pkg.
module rau_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rau_pkg::rau_cmd_type    cmd,
   input  rau_pkg::rau_status_type status
);
   import rau_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL   = 8'b0000_0010,
      ST_COMB  = 8'b0000_0100,
      ST_CHECK = 8'b0000_1000,
      ST_GCD   = 8'b0001_0000,
      ST_SHIFT = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   msel_type  mcnt_ff, mcnt_in;
   logic      valid_ff, valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      cmd      = '0;
      cmd.mul_sel = mcnt_ff;
      req_ready   = 1'b0;
      valid_in    = valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               mcnt_in  = MSEL_P0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            unique case (mcnt_ff)
               MSEL_P0: mcnt_in = MSEL_P1;
               MSEL_P1: mcnt_in = MSEL_P2;
               default: state_in = ST_COMB;
            endcase
         end
         ST_COMB: begin
            cmd.combine = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.early) begin
               state_in = ST_FIN;
            end else begin
               cmd.gcd_start = 1'b1;
               state_in      = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               state_in = ST_SHIFT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.div_setup = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Advance state, hold response valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mcnt_ff  <= MSEL_P0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

@@ src/rau_dp.sv @@
// Datapath: operand registers, shared multiplier, binary gcd, two
// restoring divider lanes and the response register. Depends on rau_pkg.
module rau_dp (
   input  logic                              clock,
   input  rau_pkg::rau_cmd_type              cmd,
   output rau_pkg::rau_status_type           status,
   input  logic [rau_pkg::OPC_W-1:0]         req_opcode,
   input  logic signed [rau_pkg::FW-1:0]     req_a_num,
   input  logic signed [rau_pkg::FW-1:0]     req_a_den,
   input  logic signed [rau_pkg::FW-1:0]     req_b_num,
   input  logic signed [rau_pkg::FW-1:0]     req_b_den,
   output logic signed [rau_pkg::FW-1:0]     rsp_res_num,
   output logic [rau_pkg::DEN_W-1:0]         rsp_res_den,
   output logic                              rsp_less,
   output logic                              rsp_equal,
   output logic                              rsp_greater,
   output logic                              rsp_zero_den_error,
   output logic                              rsp_overflow
);
   import rau_pkg::*;

   localparam logic [DW-1:0] LIM = DW'((64'd1 << (WIDTH - 1)) - 64'd1);

   function automatic smw_type to_sm(logic [FW-1:0] v);
      logic [WIDTH-1:0] w;
      smw_type          r;
      w     = v[WIDTH-1:0];
      r.neg = w[WIDTH-1];
      r.mag = r.neg ? (~w + 1'b1) : w;
      return r;
   endfunction

   function automatic smd_type ext(smw_type v);
      smd_type r;
      r.neg = v.neg;
      r.mag = DW'(v.mag);
      return r;
   endfunction

   function automatic smd_type sm_add(smd_type x, smd_type y);
      smd_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      return r;
   endfunction

   opcode_type op_ff;
   smw_type    an_ff, ad_ff, bn_ff, bd_ff;
   smd_type    p0_ff, p1_ff, p2_ff, p1n;
   smd_type    n_ff, d_ff, n_in, d_in;
   logic       err_ff, cmp_ff, nzero_ff, lt_ff, eq_ff, gt_ff;
   logic       err_in, uses_b;
   smw_type    mx, my;
   smd_type    prod;
   logic [DW-1:0]    x_ff, y_ff;
   logic [CNT_W-1:0] k_ff;
   logic [DW-1:0]    nq_ff, dq_ff, nr_ff, dr_ff, dv_ff;
   logic [DW:0]      nr_sh, dr_sh;
   logic [CNT_W-1:0] dcnt_ff;
   logic             neg, ovf;
   logic [WIDTH-1:0] rn_w;
   logic signed [FW-1:0] res_num_in, res_num_ff;
   logic [DEN_W-1:0] res_den_in, res_den_ff;
   logic lt_out_in, eq_out_in, gt_out_in, err_out_in, ovf_out_in;
   logic lt_out_ff, eq_out_ff, gt_out_ff, err_out_ff, ovf_out_ff;

   // Select multiplier operands per product slot
   always_comb begin
      unique case (cmd.mul_sel)
         MSEL_P0: begin
            mx = an_ff;
            my = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         MSEL_P1: begin
            mx = ad_ff;
            my = bn_ff;
         end
         default: begin
            mx = ad_ff;
            my = bd_ff;
         end
      endcase
      prod.mag = DW'(mx.mag) * DW'(my.mag);
      prod.neg = mx.neg ^ my.neg;
   end

   // Form numerator and denominator magnitudes and early flags
   always_comb begin
      p1n     = p1_ff;
      p1n.neg = !p1_ff.neg;
      uses_b  = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_MUL) ||
                (op_ff == OP_DIV) || (op_ff == OP_CMP);
      case (op_ff)
         OP_ADD: begin
            n_in = sm_add(p0_ff, p1_ff);
            d_in = p2_ff;
         end
         OP_SUB, OP_CMP: begin
            n_in = sm_add(p0_ff, p1n);
            d_in = p2_ff;
         end
         OP_MUL: begin
            n_in = p0_ff;
            d_in = p2_ff;
         end
         OP_DIV: begin
            n_in = p0_ff;
            d_in = p1_ff;
         end
         OP_RECIP: begin
            n_in = ext(ad_ff);
            d_in = ext(an_ff);
         end
         OP_NEG: begin
            n_in     = ext(an_ff);
            n_in.neg = !an_ff.neg;
            d_in     = ext(ad_ff);
         end
         default: begin
            n_in = ext(an_ff);
            d_in = ext(ad_ff);
         end
      endcase
      err_in = (ad_ff.mag == '0) || (uses_b && (bd_ff.mag == '0)) || (d_in.mag == '0);
   end

   // Divider lanes: shift in next dividend bit
   assign nr_sh = {nr_ff, nq_ff[DW-1]};
   assign dr_sh = {dr_ff, dq_ff[DW-1]};

   always_ff @(posedge clock) begin
      // Capture operands
      if (cmd.load) begin
         op_ff <= opcode_type'(req_opcode);
         an_ff <= to_sm(req_a_num);
         ad_ff <= to_sm(req_a_den);
         bn_ff <= to_sm(req_b_num);
         bd_ff <= to_sm(req_b_den);
      end
      // Store one product per cycle
      if (cmd.mul) begin
         case (cmd.mul_sel)
            MSEL_P0: p0_ff <= prod;
            MSEL_P1: p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
      if (cmd.combine) begin
         n_ff     <= n_in;
         d_ff     <= d_in;
         err_ff   <= err_in;
         cmp_ff   <= (op_ff == OP_CMP);
         nzero_ff <= (n_in.mag == '0);
         eq_ff    <= (n_in.mag == '0);
         lt_ff    <= (n_in.mag != '0) && (n_in.neg != (ad_ff.neg != bd_ff.neg));
         gt_ff    <= (n_in.mag != '0) && (n_in.neg == (ad_ff.neg != bd_ff.neg));
      end
      // Binary gcd: strip common twos, halve a lone even value, subtract odd values
      if (cmd.gcd_start) begin
         x_ff <= n_ff.mag;
         y_ff <= d_ff.mag;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
      // Divide both values by the odd part after removing common twos
      if (cmd.div_setup) begin
         dv_ff   <= y_ff;
         nq_ff   <= n_ff.mag >> k_ff;
         dq_ff   <= d_ff.mag >> k_ff;
         nr_ff   <= '0;
         dr_ff   <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (nr_sh >= {1'b0, dv_ff}) begin
            nr_ff <= DW'(nr_sh - {1'b0, dv_ff});
            nq_ff <= {nq_ff[DW-2:0], 1'b1};
         end else begin
            nr_ff <= DW'(nr_sh);
            nq_ff <= {nq_ff[DW-2:0], 1'b0};
         end
         if (dr_sh >= {1'b0, dv_ff}) begin
            dr_ff <= DW'(dr_sh - {1'b0, dv_ff});
            dq_ff <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            dr_ff <= DW'(dr_sh);
            dq_ff <= {dq_ff[DW-2:0], 1'b0};
         end
      end
      // Load the response register
      if (cmd.finish) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
         lt_out_ff  <= lt_out_in;
         eq_out_ff  <= eq_out_in;
         gt_out_ff  <= gt_out_in;
         err_out_ff <= err_out_in;
         ovf_out_ff <= ovf_out_in;
      end
   end

   // Range check and final result selection
   always_comb begin
      neg        = n_ff.neg ^ d_ff.neg;
      ovf        = (dq_ff > LIM) || (nq_ff > (LIM + DW'(neg)));
      rn_w       = neg ? WIDTH'(DW'(0) - nq_ff) : nq_ff[WIDTH-1:0];
      res_num_in = '0;
      res_den_in = '0;
      lt_out_in  = 1'b0;
      eq_out_in  = 1'b0;
      gt_out_in  = 1'b0;
      err_out_in = 1'b0;
      ovf_out_in = 1'b0;
      if (err_ff) begin
         err_out_in = 1'b1;
      end else if (cmp_ff) begin
         lt_out_in = lt_ff;
         eq_out_in = eq_ff;
         gt_out_in = gt_ff;
      end else if (nzero_ff) begin
         res_den_in = DEN_W'(1);
      end else if (ovf) begin
         ovf_out_in = 1'b1;
      end else begin
         res_num_in = FW'(signed'(rn_w));
         res_den_in = DEN_W'(dq_ff[WIDTH-2:0]);
      end
   end

   assign status.early    = err_ff || cmp_ff || nzero_ff;
   assign status.gcd_done = (x_ff == '0);
   assign status.div_last = (dcnt_ff == CNT_W'(DW - 1));

   assign rsp_res_num        = res_num_ff;
   assign rsp_res_den        = res_den_ff;
   assign rsp_less           = lt_out_ff;
   assign rsp_equal          = eq_out_ff;
   assign rsp_greater        = gt_out_ff;
   assign rsp_zero_den_error = err_out_ff;
   assign rsp_overflow       = ovf_out_ff;

endmodule

@@ src/rational_arithmetic_unit_core.sv @@
// Rational arithmetic unit top level: controller plus datapath.
// Errors, compare and zero results skip the gcd and the division; other results run the
// binary gcd (one subtract or shift a cycle) and then the restoring division of the
// numerator and denominator side by side.
// One item at a time; a finished beat waits in the output register.
// Synchronous reset clears the controller and the response valid.
module rational_arithmetic_unit_core (
   input logic        clock,
   input logic        reset,
   rau_req_if.sink    req_ch,
   rau_rsp_if.source  rsp_ch
);
   import rau_pkg::*;

   rau_cmd_type    cmd;
   rau_status_type status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rau_dp u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_ch.opcode),
      .req_a_num          (req_ch.a_num),
      .req_a_den          (req_ch.a_den),
      .req_b_num          (req_ch.b_num),
      .req_b_den          (req_ch.b_den),
      .rsp_res_num        (rsp_ch.res_num),
      .rsp_res_den        (rsp_ch.res_den),
      .rsp_less           (rsp_ch.less),
      .rsp_equal          (rsp_ch.equal),
      .rsp_greater        (rsp_ch.greater),
      .rsp_zero_den_error (rsp_ch.zero_den_error),
      .rsp_overflow       (rsp_ch.overflow)
   );

endmodule

@@ src/rau_checker.sv @@
// Port-level checks on the response channel, bound to the top level.
// Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rau_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [rau_pkg::FW-1:0] res_num,
   input logic [rau_pkg::DEN_W-1:0]     res_den,
   input logic                          less,
   input logic                          equal,
   input logic                          greater,
   input logic                          zero_den_error,
   input logic                          overflow
);
   import rau_pkg::*;

   `RAU_ASSERT_RST(a_reset_drop, reset |=> !rsp_valid, "response valid after reset")
   `RAU_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_num) && $stable(res_den), "stalled beat changed")
   `RAU_ASSERT(a_cmp_one, rsp_valid |-> $countones({less, equal, greater}) <= 1, "several compare flags")
   `RAU_ASSERT(a_bad_zero, rsp_valid && (zero_den_error || overflow) |-> res_num == 0 && res_den == 0 && !less && !equal && !greater, "invalid result not cleared")
   `RAU_ASSERT(a_zero_den1, rsp_valid && res_num == 0 && !zero_den_error && !overflow && !less && !equal && !greater |-> res_den == 1, "zero result without unit denominator")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .res_num        (rsp_ch.res_num),
   .res_den        (rsp_ch.res_den),
   .less           (rsp_ch.less),
   .equal          (rsp_ch.equal),
   .greater        (rsp_ch.greater),
   .zero_den_error (rsp_ch.zero_den_error),
   .overflow       (rsp_ch.overflow)
);
